// ----- design/ddo_pkg.sv -----
// Shared constants, types and the arctangent table of the odometry block.
package ddo_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int CORDIC_IW = $clog2(TRIG_ITERATIONS);
	localparam int CORDIC_W = 34;
	localparam int ATAN_W = 31;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam int DIV_IN_W = 52;
	localparam int DIV_DIGITS = DIV_IN_W / 4;
	localparam int DIV_CW = $clog2(DIV_DIGITS);

	localparam logic [2:0] REG_DIST_PER_COUNT = 3'd0;
	localparam logic [2:0] REG_TURN_PER_COUNT = 3'd1;
	localparam logic [2:0] REG_START_X = 3'd2;
	localparam logic [2:0] REG_START_Y = 3'd3;
	localparam logic [2:0] REG_START_HEADING = 3'd4;

	localparam logic [23:0] DIST_PER_COUNT_RST = 24'd315364;
	localparam logic [27:0] TURN_PER_COUNT_RST = 28'd3093187;

	typedef struct packed {
		logic load;
		logic step;
	} ddo_ctrl_t;

	function automatic logic [ATAN_W-1:0] atan_lookup(input logic [4:0] idx);
		logic [ATAN_W-1:0] r;
		case (idx)
			5'd0: r = 31'd536870912;
			5'd1: r = 31'd316933406;
			5'd2: r = 31'd167458907;
			5'd3: r = 31'd85004756;
			5'd4: r = 31'd42667331;
			5'd5: r = 31'd21354465;
			5'd6: r = 31'd10679838;
			5'd7: r = 31'd5340245;
			5'd8: r = 31'd2670163;
			5'd9: r = 31'd1335087;
			5'd10: r = 31'd667544;
			5'd11: r = 31'd333772;
			5'd12: r = 31'd166886;
			5'd13: r = 31'd83443;
			5'd14: r = 31'd41722;
			5'd15: r = 31'd20861;
			5'd16: r = 31'd10430;
			5'd17: r = 31'd5215;
			5'd18: r = 31'd2608;
			5'd19: r = 31'd1304;
			5'd20: r = 31'd652;
			5'd21: r = 31'd326;
			5'd22: r = 31'd163;
			5'd23: r = 31'd81;
			5'd24: r = 31'd41;
			5'd25: r = 31'd20;
			5'd26: r = 31'd10;
			5'd27: r = 31'd5;
			5'd28: r = 31'd3;
			5'd29: r = 31'd1;
			5'd30: r = 31'd1;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/ddo_cordic.sv -----
// Rotation-mode CORDIC that produces one sine and cosine pair, one step per cycle while ctrl.step is high.
module ddo_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ddo_pkg::ddo_ctrl_t                     ctrl,
	input  logic [31:0]                            angle,
	output logic signed [ddo_pkg::CORDIC_W-1:0]    cos_val,
	output logic signed [ddo_pkg::CORDIC_W-1:0]    sin_val,
	output logic                                   last
);
	import ddo_pkg::*;

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic [CORDIC_IW-1:0] i_q;
	logic flip_q;
	logic flip;
	logic [31:0] a;
	logic signed [CORDIC_W-1:0] xs, ys, at;

	assign flip = angle[31] ^ angle[30];
	assign a = flip ? (angle ^ 32'h8000_0000) : angle;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = CORDIC_W'({1'b0, atan_lookup(5'(i_q))});
	assign last = (i_q == CORDIC_IW'(TRIG_ITERATIONS - 1));
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (ctrl.load) begin
			i_q <= '0;
		end else if (ctrl.step) begin
			i_q <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= {{(CORDIC_W-32){a[31]}}, a};
			flip_q <= flip;
		end else if (ctrl.step) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end
endmodule

// ----- design/ddo_div6.sv -----
// Digit-serial divider by six, one radix-16 digit per cycle while ctrl.step is high.
module ddo_div6 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ddo_pkg::ddo_ctrl_t              ctrl,
	input  logic [ddo_pkg::DIV_IN_W-1:0]    dividend,
	output logic [ddo_pkg::DIV_IN_W-1:0]    quotient,
	output logic                            last
);
	import ddo_pkg::*;

	logic [DIV_IN_W-1:0] sh_q, q_q;
	logic [2:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [6:0] val;
	logic [11:0] est;
	logic [3:0] qd;
	logic [6:0] back;

	// The multiply by 43 over 256 gives the exact floor of val / 6 for val below 96.
	assign val = {rem_q, sh_q[DIV_IN_W-1 -: 4]};
	assign est = 12'(val) * 12'd43;
	assign qd = est[11:8];
	assign back = 7'(qd) * 7'd6;
	assign quotient = q_q;
	assign last = (cnt_q == DIV_CW'(DIV_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sh_q <= dividend;
			q_q <= '0;
			rem_q <= '0;
		end else if (ctrl.step) begin
			sh_q <= {sh_q[DIV_IN_W-5:0], 4'd0};
			q_q <= {q_q[DIV_IN_W-5:0], qd};
			rem_q <= 3'(val - back);
		end
	end
endmodule

// ----- design/differential_drive_odometry_core.sv -----
// Top level of the differential drive odometry block: sequencer and pose state.
//
// Input channel (in_valid/in_ready) carries absolute left and right encoder
// counts and a restart flag. Output channel (out_valid/out_ready) carries the
// pose after that item: pos_x, pos_y (Q16.16 inches, saturating) and heading
// (binary angle). The configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) is always ready; start pose writes take effect at the next restart,
// while scale writes apply to the next multiply. One item is worked on at a
// time and in_ready is low while it is in flight. A normal item uses the
// shared multiplier for travel and turn, runs three sine/cosine evaluations
// on the one CORDIC unit, then per axis scales on the multiplier, runs the
// divide-by-six unit and updates the pose, and then enters the final state.
// A restart item loads the start pose and goes straight to the final state.
// From the final state a result passes into the output register.
// The output register holds a finished item until it is taken; a new item may
// be accepted meanwhile, and its result waits in the sequencer until the
// output register is free. Reset clears the pose to the start pose reset
// values and the reference counts to zero, and restores register defaults.
module differential_drive_odometry_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ddo_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MULT  = 4'd1;
	localparam logic [3:0] ST_MULH  = 4'd2;
	localparam logic [3:0] ST_CINIT = 4'd3;
	localparam logic [3:0] ST_CORD  = 4'd4;
	localparam logic [3:0] ST_CACC  = 4'd5;
	localparam logic [3:0] ST_SM0   = 4'd6;
	localparam logic [3:0] ST_SM1   = 4'd7;
	localparam logic [3:0] ST_DLOAD = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_APPLY = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0] state_q;

	// Configuration registers.
	logic [23:0] dpc_q;
	logic [27:0] tpc_q;
	logic [31:0] start_x_q, start_y_q, start_h_q;

	// Pose and reference counts.
	logic [31:0] prev_l_q, prev_r_q;
	logic signed [31:0] est_x_q, est_y_q;
	logic [31:0] est_h_q;

	// Working registers of one item.
	logic signed [32:0] sum_q, diff_q;
	logic [56:0] tmag_q;
	logic tneg_q;
	logic [31:0] dh_q, half_q;
	logic [1:0] ang_q;
	logic axis_q;
	logic signed [34:0] sx_q, sy_q;
	logic [89:0] acc_q;
	logic mneg_q;

	logic out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [31:0] out_h_q;

	logic in_acc;
	logic [31:0] dl, dr;
	logic [32:0] mul_a, mul_b;
	logic [65:0] prod;
	logic [32:0] turn;
	logic signed [34:0] s_sel, s_abs;
	logic [31:0] ang_off;
	ddo_ctrl_t cor_ctrl, div_ctrl;
	logic signed [CORDIC_W-1:0] cos_val, sin_val;
	logic cor_last, div_last;
	logic [DIV_IN_W-1:0] quotient;
	logic signed [53:0] est_sel, delta, upd;
	logic signed [31:0] sat_val;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pos_x = out_x_q;
	assign pos_y = out_y_q;
	assign heading = out_h_q;

	assign dl = left_count - prev_l_q;
	assign dr = right_count - prev_r_q;

	// One shared unsigned multiplier serves travel, turn and both axis scalings.
	assign s_sel = axis_q ? sy_q : sx_q;
	assign s_abs = s_sel[34] ? -s_sel : s_sel;
	always_comb begin
		case (state_q)
			ST_MULT: begin
				mul_a = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
				mul_b = {9'd0, dpc_q};
			end
			ST_MULH: begin
				mul_a = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
				mul_b = {5'd0, tpc_q};
			end
			ST_SM0: begin
				mul_a = tmag_q[32:0];
				mul_b = s_abs[32:0];
			end
			ST_SM1: begin
				mul_a = {9'd0, tmag_q[56:33]};
				mul_b = s_abs[32:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = 66'(mul_a) * 66'(mul_b);
	assign turn = diff_q[32] ? -prod[32:0] : prod[32:0];

	always_comb begin
		case (ang_q)
			2'd1: ang_off = half_q;
			2'd2: ang_off = dh_q;
			default: ang_off = '0;
		endcase
	end

	assign cor_ctrl.load = (state_q == ST_CINIT);
	assign cor_ctrl.step = (state_q == ST_CORD);
	assign div_ctrl.load = (state_q == ST_DLOAD);
	assign div_ctrl.step = (state_q == ST_DIV);

	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cor_ctrl),
		.angle   (est_h_q + ang_off),
		.cos_val (cos_val),
		.sin_val (sin_val),
		.last    (cor_last)
	);

	ddo_div6 u_div6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend ({1'b0, acc_q[89:39]}),
		.quotient (quotient),
		.last     (div_last)
	);

	// Position update with saturation to the signed 32-bit range.
	assign est_sel = axis_q ? 54'(est_y_q) : 54'(est_x_q);
	assign delta = mneg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
	assign upd = est_sel + delta;
	always_comb begin
		if (upd > 54'sd2147483647) begin
			sat_val = 32'sh7FFF_FFFF;
		end else if (upd < -54'sd2147483648) begin
			sat_val = 32'sh8000_0000;
		end else begin
			sat_val = upd[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= DIST_PER_COUNT_RST;
			tpc_q <= TURN_PER_COUNT_RST;
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIST_PER_COUNT: dpc_q <= cfg_data[23:0];
				REG_TURN_PER_COUNT: tpc_q <= cfg_data[27:0];
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_START_HEADING: start_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_l_q <= '0;
			prev_r_q <= '0;
			est_x_q <= '0;
			est_y_q <= '0;
			est_h_q <= '0;
			out_valid_q <= 1'b0;
			ang_q <= '0;
			axis_q <= 1'b0;
		end else begin
			// In the final state the output valid is set below whenever the
			// register is free, so it is only cleared here in other states.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_l_q <= left_count;
						prev_r_q <= right_count;
						if (restart) begin
							est_x_q <= start_x_q;
							est_y_q <= start_y_q;
							est_h_q <= start_h_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MULT;
						end
					end
				end
				ST_MULT: state_q <= ST_MULH;
				ST_MULH: begin
					ang_q <= 2'd0;
					state_q <= ST_CINIT;
				end
				ST_CINIT: state_q <= ST_CORD;
				ST_CORD: begin
					if (cor_last) begin
						state_q <= ST_CACC;
					end
				end
				ST_CACC: begin
					if (ang_q == 2'd2) begin
						axis_q <= 1'b0;
						state_q <= ST_SM0;
					end else begin
						ang_q <= ang_q + 2'd1;
						state_q <= ST_CINIT;
					end
				end
				ST_SM0: state_q <= ST_SM1;
				ST_SM1: state_q <= ST_DLOAD;
				ST_DLOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_last) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (axis_q) begin
						est_y_q <= sat_val;
						est_h_q <= est_h_q + dh_q;
						state_q <= ST_DONE;
					end else begin
						est_x_q <= sat_val;
						axis_q <= 1'b1;
						state_q <= ST_SM0;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q <= 33'($signed(dl)) + 33'($signed(dr));
			diff_q <= 33'($signed(dr)) - 33'($signed(dl));
		end
		if (state_q == ST_MULT) begin
			tmag_q <= prod[56:0];
			tneg_q <= sum_q[32];
		end
		if (state_q == ST_MULH) begin
			dh_q <= turn[31:0];
			half_q <= turn[32:1];
			sx_q <= '0;
			sy_q <= '0;
		end
		if (state_q == ST_CACC) begin
			if (ang_q == 2'd1) begin
				sx_q <= sx_q + (35'(cos_val) <<< 2);
				sy_q <= sy_q + (35'(sin_val) <<< 2);
			end else begin
				sx_q <= sx_q + 35'(cos_val);
				sy_q <= sy_q + 35'(sin_val);
			end
		end
		if (state_q == ST_SM0) begin
			acc_q <= {24'd0, prod};
			mneg_q <= tneg_q ^ s_sel[34];
		end
		if (state_q == ST_SM1) begin
			acc_q <= acc_q + {prod[56:0], 33'd0};
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_x_q <= est_x_q;
			out_y_q <= est_y_q;
			out_h_q <= est_h_q;
		end
	end
endmodule
